[hdl/line_rasterizer_bresenham_defines.svh]
// Assertion macros shared by the line rasterizer modules.
`ifndef LINE_RASTERIZER_BRESENHAM_DEFINES_SVH
`define LINE_RASTERIZER_BRESENHAM_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define LRB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LRB_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define LRB_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/lrb_pkg.sv]
// Package with word types and constants of the line rasterizer.
`default_nettype none

package lrb_pkg;

  localparam int COORD_W      = 6;
  localparam int COLOR_W      = 32;
  localparam int TILE_SIZE_DEF = 64;
  localparam int QUEUE_DEPTH  = 2;
  localparam int ERR_W        = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } lrb_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } lrb_out_t;

  typedef struct packed {
    coord_t           major_start;
    coord_t           minor_start;
    coord_t           major_end;
    coord_t           dx;
    logic [COORD_W:0] twice_dy;
    logic             step_down;
    logic             steep;
    color_t           color;
  } lrb_desc_t;

endpackage

`default_nettype wire

[hdl/lrb_front.sv]
// Front end: clamps endpoints, picks the major axis and orders the endpoints.
`default_nettype none

module lrb_front
  import lrb_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire lrb_in_t   in_word,
  input  wire logic      q_full,
  output logic           q_push,
  output lrb_desc_t      q_desc
);

  localparam coord_t MAX_COORD = COORD_W'(TILE_SIZE - 1);

  coord_t ax, ay, bx, by;
  coord_t adx, ady;
  logic   steep;
  coord_t a_maj, a_min, b_maj, b_min;
  coord_t s_maj, s_min, e_maj, e_min;
  coord_t dmin;

  function automatic coord_t clamp(input coord_t c);
    clamp = (c > MAX_COORD) ? MAX_COORD : c;
  endfunction

  always_comb begin
    ax = clamp(in_word.start_x);
    ay = clamp(in_word.start_y);
    bx = clamp(in_word.end_x);
    by = clamp(in_word.end_y);
    adx = (ax >= bx) ? (ax - bx) : (bx - ax);
    ady = (ay >= by) ? (ay - by) : (by - ay);
    steep = adx < ady;
    a_maj = steep ? ay : ax;
    a_min = steep ? ax : ay;
    b_maj = steep ? by : bx;
    b_min = steep ? bx : by;
    if (a_maj > b_maj) begin
      s_maj = b_maj;
      s_min = b_min;
      e_maj = a_maj;
      e_min = a_min;
    end else begin
      s_maj = a_maj;
      s_min = a_min;
      e_maj = b_maj;
      e_min = b_min;
    end
    dmin = (e_min >= s_min) ? (e_min - s_min) : (s_min - e_min);
    q_desc.major_start = s_maj;
    q_desc.minor_start = s_min;
    q_desc.major_end   = e_maj;
    q_desc.dx          = e_maj - s_maj;
    q_desc.twice_dy    = {dmin, 1'b0};
    q_desc.step_down   = !(e_min > s_min);
    q_desc.steep       = steep;
    q_desc.color       = in_word.line_color;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

[hdl/lrb_queue.sv]
// Short queue of line descriptors between front end and stepper.
`default_nettype none

`include "line_rasterizer_bresenham_defines.svh"

module lrb_queue
  import lrb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire lrb_desc_t push_desc,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output lrb_desc_t      head_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrb_desc_t           mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_desc  = mem_r[rd_ptr_r];

  `LRB_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `LRB_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, count_r != '0)
  `LRB_ASSERT_NXT(a_push_count, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

`default_nettype wire

[hdl/lrb_back.sv]
// Back end: steps the doubled error term and emits one pixel per word.
`default_nettype none

`include "line_rasterizer_bresenham_defines.svh"

module lrb_back
  import lrb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire lrb_desc_t q_desc,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output lrb_out_t       out_word
);

  logic                    active_r, active_nxt;
  coord_t                  major_r, major_nxt;
  coord_t                  minor_r, minor_nxt;
  coord_t                  end_r, end_nxt;
  coord_t                  dx_r, dx_nxt;
  logic [COORD_W:0]        tdy_r, tdy_nxt;
  logic                    down_r, down_nxt;
  logic                    steep_r, steep_nxt;
  color_t                  color_r, color_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [ERR_W-1:0] err_sum, dx_s;
  logic                    last, take, over;

  always_comb begin
    last    = major_r == end_r;
    take    = active_r && !out_stall;
    q_pop   = q_valid && (!active_r || (take && last));
    dx_s    = $signed({{(ERR_W-COORD_W){1'b0}}, dx_r});
    err_sum = err_r + $signed({{(ERR_W-COORD_W-1){1'b0}}, tdy_r});
    over    = err_sum > dx_s;

    active_nxt = active_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    end_nxt    = end_r;
    dx_nxt     = dx_r;
    tdy_nxt    = tdy_r;
    down_nxt   = down_r;
    steep_nxt  = steep_r;
    color_nxt  = color_r;
    err_nxt    = err_r;

    if (q_pop) begin
      active_nxt = 1'b1;
      major_nxt  = q_desc.major_start;
      minor_nxt  = q_desc.minor_start;
      end_nxt    = q_desc.major_end;
      dx_nxt     = q_desc.dx;
      tdy_nxt    = q_desc.twice_dy;
      down_nxt   = q_desc.step_down;
      steep_nxt  = q_desc.steep;
      color_nxt  = q_desc.color;
      err_nxt    = '0;
    end else if (take && last) begin
      active_nxt = 1'b0;
    end else if (take) begin
      major_nxt = major_r + 1'b1;
      if (over) begin
        minor_nxt = down_r ? (minor_r - 1'b1) : (minor_r + 1'b1);
        err_nxt   = err_sum - (dx_s <<< 1);
      end else begin
        err_nxt = err_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    end_r   <= end_nxt;
    dx_r    <= dx_nxt;
    tdy_r   <= tdy_nxt;
    down_r  <= down_nxt;
    steep_r <= steep_nxt;
    color_r <= color_nxt;
    err_r   <= err_nxt;
  end

  assign out_valid            = active_r;
  assign out_word.pixel_x     = steep_r ? minor_r : major_r;
  assign out_word.pixel_y     = steep_r ? major_r : minor_r;
  assign out_word.pixel_color = color_r;
  assign out_word.last_pixel  = last;

  `LRB_ASSERT_IMP(a_err_bound, clk, rst_n, active_r, err_r <= dx_s)
  `LRB_ASSERT_IMP(a_major_in_span, clk, rst_n, active_r, major_r <= end_r)
  `LRB_ASSERT_NXT(a_major_step, clk, rst_n, take && !last, major_r == $past(major_r) + 1'b1)

endmodule

`default_nettype wire

[hdl/line_rasterizer_bresenham.sv]
// Top level of the Bresenham line rasterizer for one square tile.
// A request is queued, then loaded when the back end is free; its first pixel shows then.
// Each request gives (major-axis span + 1) pixels, 1 to TILE_SIZE, at one pixel per cycle
// unless stalled, by the single back-end error-term stepper; requests follow with no gap.
// A two-entry descriptor queue lets the front end accept while the back end draws.
// Synchronous active-low reset empties the queue and drops any line in progress.
`default_nettype none

module line_rasterizer_bresenham
  import lrb_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire lrb_in_t in_word,
  output logic         out_valid,
  input  wire logic    out_stall,
  output lrb_out_t     out_word
);

  logic      q_full, q_push, q_pop, q_valid;
  lrb_desc_t push_desc, head_desc;

  lrb_front #(
    .TILE_SIZE (TILE_SIZE)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  lrb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  lrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
